>>> src/wpf_pkg.sv
// Shared codes, command/status types and the arctangent table of the waypoint path follower.
`default_nettype none
package wpf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 128;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam logic [23:0] SPEED_RESET = 24'd65536;
  localparam logic [23:0] TIME_CLAMP  = 24'd16384;
  localparam int QUARTER_TURN = 12868;
  localparam int HALF_TURN    = 25736;

  // item function codes
  localparam logic [2:0] F_APPEND = 3'd0;
  localparam logic [2:0] F_START  = 3'd1;
  localparam logic [2:0] F_PAUSE  = 3'd2;
  localparam logic [2:0] F_RESUME = 3'd3;
  localparam logic [2:0] F_STOP   = 3'd4;
  localparam logic [2:0] F_TICK   = 3'd5;
  localparam logic [2:0] F_POSE   = 3'd6;

  // run status codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_NAV      = 3'd1;
  localparam logic [2:0] ST_PAUSED   = 3'd2;
  localparam logic [2:0] ST_DONE     = 3'd3;
  localparam logic [2:0] ST_CANCELED = 3'd4;

  // datapath commands
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LATCH     = 5'd1;
  localparam logic [4:0] OP_EXEC      = 5'd2;
  localparam logic [4:0] OP_BUDGET    = 5'd3;
  localparam logic [4:0] OP_RDREQ     = 5'd4;
  localparam logic [4:0] OP_DIFF      = 5'd5;
  localparam logic [4:0] OP_MUL_AX    = 5'd6;
  localparam logic [4:0] OP_MUL_AY    = 5'd7;
  localparam logic [4:0] OP_MUL_STEP  = 5'd8;
  localparam logic [4:0] OP_SQRT_INIT = 5'd9;
  localparam logic [4:0] OP_SQRT_STEP = 5'd10;
  localparam logic [4:0] OP_SNAP      = 5'd11;
  localparam logic [4:0] OP_MUL_BX    = 5'd12;
  localparam logic [4:0] OP_MUL_BY    = 5'd13;
  localparam logic [4:0] OP_DIV_INIT  = 5'd14;
  localparam logic [4:0] OP_DIV_STEP  = 5'd15;
  localparam logic [4:0] OP_MOVE      = 5'd16;
  localparam logic [4:0] OP_CRD_INIT  = 5'd17;
  localparam logic [4:0] OP_CRD_STEP  = 5'd18;
  localparam logic [4:0] OP_HEAD      = 5'd19;
  localparam logic [4:0] OP_FINISH    = 5'd20;
  localparam logic [4:0] OP_OUT       = 5'd21;

  typedef struct packed {
    logic [4:0] op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic more;
    logic fits;
    logic out_busy;
  } stat_t;

  // rounded Q3.13 atan(2^-i)
  function automatic logic [12:0] atan_entry(input logic [4:0] i);
    logic [12:0] v;
    case (i)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/waypoint_path_follower.sv
// Top level of the waypoint path follower: controller, datapath and route store.
//
// Input channel: in_valid/in_stall carry one command word (func, pos_x, pos_y,
// heading, elapsed, first_point); a word is taken when in_valid is high and
// in_stall is low. Every command word yields exactly one result word on the
// out_valid/out_stall channel with the status, reject flag, pose and counts.
// Configuration: travel_speed is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high, write only while the block is idle.
// A moving tick computes, for every waypoint it snaps to, the distance with two
// shift-add squares and a square root; for the final partial move it computes
// the same distance, then two multiplies, two divides and the CORDIC loop.
// One command word is processed at a time; the next is taken once the result
// is loaded into the output register, even while that result is still stalled.
// Reset clears the route, the pose and the status to idle and sets the speed
// to 1.0 m/s. A stalled result word holds until taken.
`default_nettype none
module waypoint_path_follower #(
  parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = wpf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        travel_speed,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic [23:0]        elapsed,
  input  logic               first_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         run_status,
  output logic               rejected,
  output logic signed [31:0] pose_x_out,
  output logic signed [31:0] pose_y_out,
  output logic signed [15:0] pose_heading,
  output logic [7:0]         completed,
  output logic [7:0]         total
);

  localparam int AW = $clog2(MAX_WAYPOINTS);

  wpf_pkg::cmd_t  cmd;
  wpf_pkg::stat_t st;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [79:0]    ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  wpf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  wpf_dp #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_valid),
    .travel_speed (travel_speed),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading),
    .elapsed      (elapsed),
    .first_point  (first_point),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .run_status   (run_status),
    .rejected     (rejected),
    .pose_x_out   (pose_x_out),
    .pose_y_out   (pose_y_out),
    .pose_heading (pose_heading),
    .completed    (completed),
    .total        (total)
  );

  // route store: {x, y, heading} per waypoint
  wpf_ram #(
    .WIDTH(80),
    .DEPTH(MAX_WAYPOINTS)
  ) u_route (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> src/wpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wpf_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/wpf_ctrl.sv
// Controller state machine that sequences the path follower datapath.
`default_nettype none
module wpf_ctrl #(
  parameter int CORDIC_STEPS = wpf_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  wpf_pkg::stat_t st,
  output wpf_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_CHECK = 5'd2;
  localparam logic [4:0] S_DIFF = 5'd3;
  localparam logic [4:0] S_MXI = 5'd4;
  localparam logic [4:0] S_MX = 5'd5;
  localparam logic [4:0] S_MYI = 5'd6;
  localparam logic [4:0] S_MY = 5'd7;
  localparam logic [4:0] S_SQI = 5'd8;
  localparam logic [4:0] S_SQ = 5'd9;
  localparam logic [4:0] S_CMP = 5'd10;
  localparam logic [4:0] S_MBX = 5'd11;
  localparam logic [4:0] S_DVXI = 5'd12;
  localparam logic [4:0] S_DVX = 5'd13;
  localparam logic [4:0] S_MBYI = 5'd14;
  localparam logic [4:0] S_MBY = 5'd15;
  localparam logic [4:0] S_DVYI = 5'd16;
  localparam logic [4:0] S_DVY = 5'd17;
  localparam logic [4:0] S_MOVE = 5'd18;
  localparam logic [4:0] S_CRI = 5'd19;
  localparam logic [4:0] S_CR = 5'd20;
  localparam logic [4:0] S_HEAD = 5'd21;
  localparam logic [4:0] S_FIN = 5'd22;
  localparam logic [4:0] S_OUT = 5'd23;

  localparam logic [5:0] MUL_LAST  = 6'd31;
  localparam logic [5:0] SQRT_LAST = 6'd32;
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] CRD_LAST  = 6'(CORDIC_STEPS - 1);

  logic [4:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd.op     = wpf_pkg::OP_NONE;
    cmd.idx    = cnt[4:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = wpf_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.tick_go) begin
          cmd.op     = wpf_pkg::OP_BUDGET;
          state_next = S_CHECK;
        end else begin
          cmd.op     = wpf_pkg::OP_EXEC;
          state_next = S_OUT;
        end
      end
      S_CHECK: begin
        if (st.more) begin
          cmd.op     = wpf_pkg::OP_RDREQ;
          state_next = S_DIFF;
        end else begin
          cmd.op     = wpf_pkg::OP_FINISH;
          state_next = S_OUT;
        end
      end
      S_DIFF: begin
        cmd.op     = wpf_pkg::OP_DIFF;
        state_next = S_MXI;
      end
      S_MXI: begin
        cmd.op     = wpf_pkg::OP_MUL_AX;
        state_next = S_MX;
      end
      S_MX: begin
        cmd.op   = wpf_pkg::OP_MUL_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) state_next = S_MYI;
      end
      S_MYI: begin
        cmd.op     = wpf_pkg::OP_MUL_AY;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.op   = wpf_pkg::OP_MUL_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) state_next = S_SQI;
      end
      S_SQI: begin
        cmd.op     = wpf_pkg::OP_SQRT_INIT;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op   = wpf_pkg::OP_SQRT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == SQRT_LAST) state_next = S_CMP;
      end
      S_CMP: begin
        if (st.fits) begin
          cmd.op     = wpf_pkg::OP_SNAP;
          state_next = S_CHECK;
        end else begin
          cmd.op     = wpf_pkg::OP_MUL_BX;
          state_next = S_MBX;
        end
      end
      S_MBX: begin
        cmd.op   = wpf_pkg::OP_MUL_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) state_next = S_DVXI;
      end
      S_DVXI: begin
        cmd.op     = wpf_pkg::OP_DIV_INIT;
        state_next = S_DVX;
      end
      S_DVX: begin
        cmd.op   = wpf_pkg::OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_LAST) state_next = S_MBYI;
      end
      S_MBYI: begin
        cmd.op     = wpf_pkg::OP_MUL_BY;
        state_next = S_MBY;
      end
      S_MBY: begin
        cmd.op   = wpf_pkg::OP_MUL_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) state_next = S_DVYI;
      end
      S_DVYI: begin
        cmd.op     = wpf_pkg::OP_DIV_INIT;
        state_next = S_DVY;
      end
      S_DVY: begin
        cmd.op   = wpf_pkg::OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_LAST) state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.op     = wpf_pkg::OP_MOVE;
        state_next = S_CRI;
      end
      S_CRI: begin
        cmd.op     = wpf_pkg::OP_CRD_INIT;
        state_next = S_CR;
      end
      S_CR: begin
        cmd.op   = wpf_pkg::OP_CRD_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == CRD_LAST) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.op     = wpf_pkg::OP_HEAD;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = wpf_pkg::OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.op     = wpf_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/wpf_dp.sv
// Datapath: route bookkeeping, pose, shift-add multiplier, square root, divider and CORDIC.
`default_nettype none
module wpf_dp #(
  parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wpf_pkg::cmd_t                    cmd,
  output wpf_pkg::stat_t                   st,
  input  logic                             cfg_we,
  input  logic [23:0]                      travel_speed,
  input  logic [2:0]                       func,
  input  logic signed [31:0]               pos_x,
  input  logic signed [31:0]               pos_y,
  input  logic signed [15:0]               heading,
  input  logic [23:0]                      elapsed,
  input  logic                             first_point,
  output logic                             ram_we,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] ram_waddr,
  output logic [79:0]                      ram_wdata,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] ram_raddr,
  input  logic [79:0]                      ram_rdata,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [2:0]                       run_status,
  output logic                             rejected,
  output logic signed [31:0]               pose_x_out,
  output logic signed [31:0]               pose_y_out,
  output logic signed [15:0]               pose_heading,
  output logic [7:0]                       completed,
  output logic [7:0]                       total
);

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam logic signed [16:0] HT17 = 17'(wpf_pkg::HALF_TURN);
  localparam logic signed [16:0] QT17 = 17'(wpf_pkg::QUARTER_TURN);

  // architectural state
  logic [2:0]         status;
  logic [CW-1:0]      length, nidx;
  logic signed [31:0] cur_x, cur_y;
  logic signed [15:0] cur_hd;
  logic [23:0]        speed;

  // latched item
  logic [2:0]         it_func;
  logic signed [31:0] it_x, it_y;
  logic signed [15:0] it_h;
  logic [23:0]        it_elapsed;
  logic               it_first;
  logic               rej;

  // waypoint and arithmetic registers
  logic signed [31:0] wx, wy;
  logic signed [15:0] wh;
  logic signed [32:0] dx, dy;
  logic [31:0]        ax, ay, ma, mx;
  logic [21:0]        budget;
  logic [63:0]        p, sx;
  logic [65:0]        rad;
  logic [35:0]        sqrem;
  logic [32:0]        root, drem;
  logic signed [59:0] cx, cy;
  logic signed [16:0] cz;

  // combinational helpers
  logic               active;
  logic [CW-1:0]      len_eff;
  logic               full;
  logic [14:0]        tclamp;
  logic [38:0]        bprod;
  logic signed [32:0] ndx, ndy;
  logic [32:0]        msum;
  logic [35:0]        sq_r, sq_trial;
  logic [33:0]        dv_r;
  logic               dv_ge;
  logic signed [59:0] xs, ys, x0, y0;
  logic signed [16:0] at;
  logic signed [33:0] mvx, mvy;

  assign active  = (status == wpf_pkg::ST_NAV) || (status == wpf_pkg::ST_PAUSED);
  assign len_eff = it_first ? '0 : length;
  assign full    = (len_eff >= CW'(MAX_WAYPOINTS));

  assign st.tick_go  = (it_func == wpf_pkg::F_TICK) && (status == wpf_pkg::ST_NAV) &&
                       (it_elapsed != 24'd0);
  assign st.more     = (nidx < length);
  assign st.fits     = (root <= 33'(budget));
  assign st.out_busy = out_valid && out_stall;

  // route store write on accepted append, read at the next waypoint
  assign ram_we    = (cmd.op == wpf_pkg::OP_EXEC) && (it_func == wpf_pkg::F_APPEND) &&
                     !active && !full;
  assign ram_waddr = len_eff[AW-1:0];
  assign ram_wdata = {it_x, it_y, it_h};
  assign ram_raddr = nidx[AW-1:0];

  // travel budget
  assign tclamp = (it_elapsed < wpf_pkg::TIME_CLAMP) ? it_elapsed[14:0]
                                                      : wpf_pkg::TIME_CLAMP[14:0];
  assign bprod  = 39'(speed) * 39'(tclamp);

  // offsets to the waypoint just read
  assign ndx = $signed({ram_rdata[79], ram_rdata[79:48]}) - $signed({cur_x[31], cur_x});
  assign ndy = $signed({ram_rdata[47], ram_rdata[47:16]}) - $signed({cur_y[31], cur_y});

  // shift-add multiplier step
  assign msum = {1'b0, p[63:32]} + (p[0] ? {1'b0, ma} : 33'd0);

  // square root step, two radicand bits a step
  assign sq_r     = {sqrem[33:0], rad[65:64]};
  assign sq_trial = {1'b0, root, 2'b01};

  // restoring divider step
  assign dv_r  = {drem, p[63]};
  assign dv_ge = (dv_r >= {1'b0, root});

  // CORDIC step and start vector
  assign xs = cx >>> cmd.idx;
  assign ys = cy >>> cmd.idx;
  assign at = $signed({4'b0, wpf_pkg::atan_entry(cmd.idx)});
  assign x0 = $signed({{3{dx[32]}}, dx, 24'd0});
  assign y0 = $signed({{3{dy[32]}}, dy, 24'd0});

  // partial move
  assign mvx = $signed({{2{cur_x[31]}}, cur_x}) +
               (dx[32] ? -$signed({2'b0, mx}) : $signed({2'b0, mx}));
  assign mvy = $signed({{2{cur_y[31]}}, cur_y}) +
               (dy[32] ? -$signed({2'b0, p[31:0]}) : $signed({2'b0, p[31:0]}));

  // control-carrying state
  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= wpf_pkg::ST_IDLE;
      length    <= '0;
      nidx      <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_hd    <= '0;
      speed     <= wpf_pkg::SPEED_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) speed <= travel_speed;
      if (cmd.op == wpf_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        wpf_pkg::OP_EXEC: begin
          case (it_func)
            wpf_pkg::F_APPEND: begin
              if (!active) begin
                if (it_first) nidx <= '0;
                if (!full) begin
                  length <= len_eff + 1'b1;
                end else begin
                  length <= len_eff;
                end
              end
            end
            wpf_pkg::F_START: begin
              if (!active && length != '0) begin
                nidx   <= '0;
                status <= wpf_pkg::ST_NAV;
              end
            end
            wpf_pkg::F_PAUSE: begin
              if (status == wpf_pkg::ST_NAV) status <= wpf_pkg::ST_PAUSED;
            end
            wpf_pkg::F_RESUME: begin
              if (status == wpf_pkg::ST_PAUSED) status <= wpf_pkg::ST_NAV;
            end
            wpf_pkg::F_STOP: begin
              if (active) status <= wpf_pkg::ST_CANCELED;
            end
            wpf_pkg::F_POSE: begin
              if (!active) begin
                cur_x  <= it_x;
                cur_y  <= it_y;
                cur_hd <= it_h;
              end
            end
            default: begin
            end
          endcase
        end
        wpf_pkg::OP_SNAP: begin
          cur_x  <= wx;
          cur_y  <= wy;
          cur_hd <= wh;
          nidx   <= nidx + 1'b1;
        end
        wpf_pkg::OP_MOVE: begin
          cur_x <= mvx[31:0];
          cur_y <= mvy[31:0];
        end
        wpf_pkg::OP_HEAD: begin
          if (cz > HT17) begin
            cur_hd <= HT17[15:0];
          end else if (cz < -HT17) begin
            cur_hd <= 16'(-HT17);
          end else begin
            cur_hd <= cz[15:0];
          end
        end
        wpf_pkg::OP_FINISH: begin
          if (nidx == length) status <= wpf_pkg::ST_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      wpf_pkg::OP_LATCH: begin
        it_func    <= func;
        it_x       <= pos_x;
        it_y       <= pos_y;
        it_h       <= heading;
        it_elapsed <= elapsed;
        it_first   <= first_point;
        rej        <= 1'b0;
      end
      wpf_pkg::OP_EXEC: begin
        case (it_func)
          wpf_pkg::F_APPEND: rej <= active || full;
          wpf_pkg::F_START:  rej <= active || (length == '0);
          wpf_pkg::F_PAUSE:  rej <= (status != wpf_pkg::ST_NAV);
          wpf_pkg::F_RESUME: rej <= (status != wpf_pkg::ST_PAUSED);
          wpf_pkg::F_POSE:   rej <= active;
          default:           rej <= 1'b0;
        endcase
      end
      wpf_pkg::OP_BUDGET: begin
        budget <= bprod[37:16];
      end
      wpf_pkg::OP_DIFF: begin
        wx <= $signed(ram_rdata[79:48]);
        wy <= $signed(ram_rdata[47:16]);
        wh <= $signed(ram_rdata[15:0]);
        dx <= ndx;
        dy <= ndy;
        ax <= ndx[32] ? 32'(-ndx) : ndx[31:0];
        ay <= ndy[32] ? 32'(-ndy) : ndy[31:0];
      end
      wpf_pkg::OP_MUL_AX: begin
        ma <= ax;
        p  <= {32'd0, ax};
      end
      wpf_pkg::OP_MUL_AY: begin
        sx <= p;
        ma <= ay;
        p  <= {32'd0, ay};
      end
      wpf_pkg::OP_MUL_BX: begin
        ma <= ax;
        p  <= {42'd0, budget};
      end
      wpf_pkg::OP_MUL_BY: begin
        mx <= p[31:0];
        ma <= ay;
        p  <= {42'd0, budget};
      end
      wpf_pkg::OP_MUL_STEP: begin
        p <= {msum, p[31:1]};
      end
      wpf_pkg::OP_SQRT_INIT: begin
        rad   <= {1'b0, 65'({1'b0, sx} + {1'b0, p})};
        sqrem <= '0;
        root  <= '0;
      end
      wpf_pkg::OP_SQRT_STEP: begin
        rad <= {rad[63:0], 2'b00};
        if (sq_r >= sq_trial) begin
          sqrem <= sq_r - sq_trial;
          root  <= {root[31:0], 1'b1};
        end else begin
          sqrem <= sq_r;
          root  <= {root[31:0], 1'b0};
        end
      end
      wpf_pkg::OP_SNAP: begin
        budget <= budget - root[21:0];
      end
      wpf_pkg::OP_DIV_INIT: begin
        drem <= '0;
      end
      wpf_pkg::OP_DIV_STEP: begin
        drem <= dv_ge ? 33'(dv_r - {1'b0, root}) : dv_r[32:0];
        p    <= {p[62:0], dv_ge};
      end
      wpf_pkg::OP_CRD_INIT: begin
        if (dx[32]) begin
          if (!dy[32]) begin
            cx <= y0;
            cy <= -x0;
            cz <= QT17;
          end else begin
            cx <= -y0;
            cy <= x0;
            cz <= -QT17;
          end
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      wpf_pkg::OP_CRD_STEP: begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end
      end
      wpf_pkg::OP_OUT: begin
        run_status   <= status;
        rejected     <= rej;
        pose_x_out   <= cur_x;
        pose_y_out   <= cur_y;
        pose_heading <= cur_hd;
        completed    <= 8'(nidx);
        total        <= 8'(length);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_index_in_route: assert property (@(posedge clk) disable iff (rst) nidx <= length)
    else $error("waypoint index beyond route length");
  a_nav_has_route: assert property (@(posedge clk) disable iff (rst)
    (status == wpf_pkg::ST_NAV) |-> (length != '0))
    else $error("navigating with an empty route");
  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == wpf_pkg::OP_OUT) |=> out_valid)
    else $error("result word not presented after load");
  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == wpf_pkg::OP_OUT) |-> !(out_valid && out_stall))
    else $error("result word overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> dv/waypoint_path_follower_test.sv
// Self-checking testbench for the waypoint path follower: command words in, pose/status words out.
`timescale 1ns / 1ps
module waypoint_path_follower_test;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [23:0]        elapsed;
    logic               first_point;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         run_status;
    logic               rejected;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic [7:0]         completed;
    logic [7:0]         total;
  } pose_word_t;

  localparam int ROUTE_DEPTH = 128;
  localparam int CORDIC_ITERS = 16;
  localparam longint CYCLE_LIMIT = 10000000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [23:0] travel_speed;
  logic in_valid, in_stall;
  logic [2:0] func;
  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] heading;
  logic [23:0] elapsed;
  logic first_point;
  logic out_valid, out_stall;
  logic [2:0] run_status;
  logic rejected;
  logic signed [31:0] pose_x_out, pose_y_out;
  logic signed [15:0] pose_heading;
  logic [7:0] completed, total;
  logic in_fire;

  waypoint_path_follower DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .travel_speed(travel_speed),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .elapsed(elapsed), .first_point(first_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_status(run_status), .rejected(rejected),
    .pose_x_out(pose_x_out), .pose_y_out(pose_y_out), .pose_heading(pose_heading),
    .completed(completed), .total(total)
  );

  // predictor state
  logic signed [31:0] wp_x [ROUTE_DEPTH] = '{default: '0};
  logic signed [31:0] wp_y [ROUTE_DEPTH] = '{default: '0};
  logic signed [15:0] wp_h [ROUTE_DEPTH] = '{default: '0};
  int unsigned route_len = 0, next_wp = 0;
  logic [2:0] nav_state = wpf_pkg::ST_IDLE;
  logic signed [31:0] at_x = 0, at_y = 0;
  logic signed [15:0] at_h = 0;
  logic [23:0] speed_now;

  cmd_word_t  cmd_queue[$];
  pose_word_t expected_poses[$];
  int sender_idle_pct, receiver_stall_pct;
  int mismatches = 0, words_sent = 0, words_checked = 0, ticks_moving = 0;
  longint cycle_count = 0;

  task automatic add_cmd(input cmd_word_t c);
    cmd_queue = {cmd_queue, c};
  endtask

  // floor(sqrt(v)) for v < 2^66
  function automatic logic [63:0] root66(input logic [65:0] v);
    logic [65:0] rem, trial;
    logic [63:0] r;
    rem = 0; r = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
      trial = ({2'b0, r} << 2) | 66'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // vectoring arctangent, Q3.13 result
  function automatic logic signed [15:0] bearing(input longint dy, input longint dx);
    longint x, y, z, t, xs, ys;
    x = dx * 64'sd16777216; y = dy * 64'sd16777216; z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = wpf_pkg::QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -wpf_pkg::QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(wpf_pkg::atan_entry(5'(i)));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(wpf_pkg::atan_entry(5'(i)));
      end
    end
    if (z > wpf_pkg::HALF_TURN) z = wpf_pkg::HALF_TURN;
    if (z < -wpf_pkg::HALF_TURN) z = -wpf_pkg::HALF_TURN;
    return 16'(z);
  endfunction

  // walk the route for one tick
  task automatic advance_along_route(input logic [23:0] dt);
    logic [63:0] budget, seg_len, ax, ay, mx, my;
    logic [65:0] sq;
    longint dx, dy;
    if (nav_state != wpf_pkg::ST_NAV || dt == 0) return;
    budget = (64'(speed_now) *
              64'(dt < wpf_pkg::TIME_CLAMP ? dt : wpf_pkg::TIME_CLAMP)) >> 16;
    if (budget != 0) ticks_moving++;
    while (next_wp < route_len) begin
      dx = longint'(wp_x[next_wp]) - longint'(at_x);
      dy = longint'(wp_y[next_wp]) - longint'(at_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      seg_len = root66(sq);
      if (seg_len <= budget) begin
        at_x = wp_x[next_wp]; at_y = wp_y[next_wp]; at_h = wp_h[next_wp];
        budget -= seg_len;
        next_wp++;
      end else begin
        mx = 64'((128'(ax) * 128'(budget)) / 128'(seg_len));
        my = 64'((128'(ay) * 128'(budget)) / 128'(seg_len));
        at_x = 32'(longint'(at_x) + (dx < 0 ? -longint'(mx) : longint'(mx)));
        at_y = 32'(longint'(at_y) + (dy < 0 ? -longint'(my) : longint'(my)));
        at_h = bearing(dy, dx);
        break;
      end
    end
    if (next_wp == route_len) nav_state = wpf_pkg::ST_DONE;
  endtask

  task automatic predict_pose(input cmd_word_t c);
    pose_word_t p;
    bit busy, refuse;
    busy = nav_state == wpf_pkg::ST_NAV || nav_state == wpf_pkg::ST_PAUSED;
    refuse = 0;
    case (c.func)
      wpf_pkg::F_APPEND: begin
        if (busy) refuse = 1;
        else begin
          if (c.first_point) begin
            route_len = 0; next_wp = 0;
          end
          if (route_len >= ROUTE_DEPTH) refuse = 1;
          else begin
            wp_x[route_len] = c.pos_x; wp_y[route_len] = c.pos_y;
            wp_h[route_len] = c.heading;
            route_len++;
          end
        end
      end
      wpf_pkg::F_START: begin
        if (busy || route_len == 0) refuse = 1;
        else begin
          next_wp = 0; nav_state = wpf_pkg::ST_NAV;
        end
      end
      wpf_pkg::F_PAUSE:
        if (nav_state != wpf_pkg::ST_NAV) refuse = 1; else nav_state = wpf_pkg::ST_PAUSED;
      wpf_pkg::F_RESUME:
        if (nav_state != wpf_pkg::ST_PAUSED) refuse = 1; else nav_state = wpf_pkg::ST_NAV;
      wpf_pkg::F_STOP: if (busy) nav_state = wpf_pkg::ST_CANCELED;
      wpf_pkg::F_TICK: advance_along_route(c.elapsed);
      wpf_pkg::F_POSE: begin
        if (busy) refuse = 1;
        else begin
          at_x = c.pos_x; at_y = c.pos_y; at_h = c.heading;
        end
      end
      default: ;
    endcase
    p.run_status = nav_state; p.rejected = refuse;
    p.pose_x = at_x; p.pose_y = at_y; p.pose_heading = at_h;
    p.completed = 8'(next_wp); p.total = 8'(route_len);
    expected_poses = {expected_poses, p};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in word %0d: %s got %0d expected %0d", words_checked, what, got, want);
    mismatches++;
  endtask

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // input word taken at this rising edge
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && !in_stall;
  end

  // driver: one word from the pending queue, updated on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0; out_stall <= 0;
      func <= wpf_pkg::F_STOP; pos_x <= 0; pos_y <= 0; heading <= 0;
      elapsed <= 0; first_point <= 0;
    end else begin
      if (in_fire) begin
        predict_pose(cmd_queue.pop_front());
        words_sent++;
      end
      if (!in_valid || in_fire) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1;
          {func, pos_x, pos_y, heading, elapsed, first_point} <= cmd_queue[0];
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= $urandom_range(99) < receiver_stall_pct;
    end
  end

  // monitor: compare each result word against the oldest prediction
  always @(posedge clk) begin
    pose_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("result word with none expected", 1, 0);
      end else begin
        w = expected_poses.pop_front();
        if (run_status !== w.run_status) report_mismatch("run_status", run_status, w.run_status);
        if (rejected !== w.rejected) report_mismatch("rejected", rejected, w.rejected);
        if (pose_x_out !== w.pose_x) report_mismatch("pose_x", pose_x_out, w.pose_x);
        if (pose_y_out !== w.pose_y) report_mismatch("pose_y", pose_y_out, w.pose_y);
        if (pose_heading !== w.pose_heading)
          report_mismatch("heading", pose_heading, w.pose_heading);
        if (completed !== w.completed) report_mismatch("completed", completed, w.completed);
        if (total !== w.total) report_mismatch("total", total, w.total);
      end
      words_checked++;
    end
  end

  function automatic cmd_word_t make_cmd(input logic [2:0] f, input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [15:0] h,
                                         input logic [23:0] dt, input logic fp);
    cmd_word_t c;
    c.func = f; c.pos_x = x; c.pos_y = y; c.heading = h; c.elapsed = dt; c.first_point = fp;
    return c;
  endfunction

  function automatic logic signed [15:0] rand_heading();
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  // wait until the queue has drained and every result is in
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || expected_poses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_speed(input logic [23:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1; travel_speed <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    speed_now = v;
  endtask

  // a well-formed mission with random content; short hops mostly
  task automatic queue_mission(input int n_pts, input int span);
    logic signed [31:0] bx, by;
    bx = $urandom; by = $urandom;
    bx = bx >>> 4; by = by >>> 4;
    if ($urandom_range(3) == 0)
      add_cmd(make_cmd(wpf_pkg::F_POSE, bx, by, rand_heading(), 24'($urandom),
                       1'($urandom)));
    for (int i = 0; i < n_pts; i++) begin
      bx = bx + $signed($urandom_range(2 * span)) - span;
      by = by + $signed($urandom_range(2 * span)) - span;
      add_cmd(make_cmd(wpf_pkg::F_APPEND, bx, by, rand_heading(), 24'($urandom), i == 0));
    end
    add_cmd(make_cmd(wpf_pkg::F_START, $urandom, $urandom, 16'($urandom), 24'($urandom),
                     1'($urandom)));
    for (int i = 0; i < n_pts * 3 + 2; i++) begin
      case ($urandom_range(19))
        0: add_cmd(make_cmd(wpf_pkg::F_PAUSE, $urandom, $urandom, 0, 0, 0));
        1: add_cmd(make_cmd(wpf_pkg::F_RESUME, $urandom, $urandom, 0, 0, 0));
        2: add_cmd(make_cmd(wpf_pkg::F_STOP, 0, 0, 0, 0, 0));
        3: add_cmd(make_cmd(3'($urandom_range(6)), $urandom, $urandom,
                            rand_heading(), 24'($urandom), 1'($urandom)));
        4: add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 24'($urandom), 0));
        default: add_cmd(make_cmd(wpf_pkg::F_TICK, $urandom, $urandom, 0,
                                  24'($urandom_range(20000)), 0));
      endcase
    end
  endtask

  task automatic run_random(input int n_words);
    int goal;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      if (cmd_queue.size() < 8) begin
        if ($urandom_range(9) < 7) queue_mission($urandom_range(1, 5),
                                                 $urandom_range(3) == 0 ? 32'h7fff_ffff >> 2
                                                                        : 32'h3_0000);
        else add_cmd(make_cmd(3'($urandom), $urandom, $urandom,
                              rand_heading(), 24'($urandom), 1'($urandom)));
      end
      @(posedge clk);
    end
  endtask

  initial begin
    rst = 1; cfg_valid = 0; travel_speed = wpf_pkg::SPEED_RESET;
    speed_now = wpf_pkg::SPEED_RESET; sender_idle_pct = 0; receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: refusals when empty, extreme coordinates, coincident points, tick clamp
    add_cmd(make_cmd(wpf_pkg::F_START, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_PAUSE, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_RESUME, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_STOP, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 24'hffffff, 0));
    add_cmd(make_cmd(3'd7, -1, -1, -1, 24'hffffff, 1));
    add_cmd(make_cmd(wpf_pkg::F_POSE, 32'sh8000_0000, 32'sh7fff_ffff, -25736, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 25736, 0, 1));
    add_cmd(make_cmd(wpf_pkg::F_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, -25736, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 100, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_START, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_APPEND, 0, 0, 0, 0, 1));
    add_cmd(make_cmd(wpf_pkg::F_POSE, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_START, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_PAUSE, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 16384, 0));
    add_cmd(make_cmd(wpf_pkg::F_RESUME, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 24'hffffff, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 1, 0));
    add_cmd(make_cmd(wpf_pkg::F_STOP, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_APPEND, 1, -1, 0, 0, 1));
    add_cmd(make_cmd(wpf_pkg::F_START, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 24'hffffff, 0));

    // fill the store to capacity, then one more append is refused
    drain();
    for (int i = 0; i < ROUTE_DEPTH + 1; i++)
      add_cmd(make_cmd(wpf_pkg::F_APPEND, $urandom_range(4095), $urandom_range(4095),
                       rand_heading(), 0, i == 0));
    add_cmd(make_cmd(wpf_pkg::F_START, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(wpf_pkg::F_TICK, 0, 0, 0, 24'hffffff, 0));
    // sender holds off until all results are back
    drain();

    // random phases with speed changes, extremes included
    write_speed(24'hffffff);
    sender_idle_pct = 0;  receiver_stall_pct = 0;  run_random(80);
    write_speed(24'd0);
    sender_idle_pct = 62; receiver_stall_pct = 0;  run_random(50);
    write_speed(24'($urandom_range(16777215)));
    sender_idle_pct = 0;  receiver_stall_pct = 62; run_random(80);
    write_speed(24'($urandom_range(4 << 16)));
    sender_idle_pct = 13; receiver_stall_pct = 13; run_random(70);
    sender_idle_pct = 0;  receiver_stall_pct = 0;  run_random(20);

    drain();
    repeat (600) @(posedge clk);
    $display("checked %0d result words from %0d commands, %0d moving ticks",
             words_checked, words_sent, ticks_moving);
    $display("idle/stall mixes, speeds 0 to max, full store and all refusals exercised");
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_poses.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
